// ----- src/nlr_pkg.sv -----
// Shared types, character constants and character-class helpers for the
// numeric literal recognizer. No dependencies.
package nlr_pkg;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_LO_U  = 8'h75;
  localparam logic [7:0] CH_UP_U  = 8'h55;
  localparam logic [7:0] CH_LO_L  = 8'h6C;
  localparam logic [7:0] CH_UP_L  = 8'h4C;

  // Largest value the match_length field can carry.
  localparam int unsigned OUT_LEN_MAX = 255;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       span_end;
  } in_t;

  typedef struct packed {
    logic       matched;
    logic [7:0] match_length;
  } out_t;

  typedef enum logic [9:0] {
    PH_START   = 10'b00_0000_0001,
    PH_SIGN    = 10'b00_0000_0010,
    PH_INT     = 10'b00_0000_0100,
    PH_FRAC    = 10'b00_0000_1000,
    PH_HEX     = 10'b00_0001_0000,
    PH_BIN     = 10'b00_0010_0000,
    PH_EXP     = 10'b00_0100_0000,
    PH_EXPSIGN = 10'b00_1000_0000,
    PH_EXPDIG  = 10'b01_0000_0000,
    PH_SUFFIX  = 10'b10_0000_0000
  } phase_t;

  // Outcome of one byte in the current phase.
  typedef struct packed {
    phase_t phase;
    logic   take;
    logic   decide;
    logic   fail;
  } step_t;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_hexd(input logic [7:0] c);
    return is_dec(c) || ((c >= CH_LO_A) && (c <= CH_LO_F)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_F));
  endfunction

  function automatic logic is_sfx(input logic [7:0] c);
    return (c == CH_LO_U) || (c == CH_UP_U) || (c == CH_LO_L) || (c == CH_UP_L);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

endpackage

// ----- src/number_literal_recognizer.sv -----
// Top level of the numeric literal recognizer: input register, lexer state,
// result register. Depends on nlr_pkg and nlr_step.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+---------------------------------
//   byte     | byte_valid / byte_ready      | byte_data   (nlr_pkg::in_t)
//   result   | result_valid / result_ready  | result_data (nlr_pkg::out_t)
//
// One byte per clock while no span_end byte stalls. Each byte is held in the input
// register, where the phase logic updates the lexer state; a span_end byte then
// loads the result register from that state when it leaves the input register.
// Only a span_end byte can stall, and only while the result register is full
// and not being taken. Reset clears the valid bits and the lexer state.
module number_literal_recognizer #(
  parameter int unsigned MAX_LEN = 255
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  nlr_pkg::in_t        byte_data,
  output logic                result_valid,
  input  logic                result_ready,
  output nlr_pkg::out_t       result_data
);

  localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);

  logic            s1_valid;
  nlr_pkg::in_t    s1_data;
  logic            s1_fire;

  nlr_pkg::phase_t phase;
  nlr_pkg::phase_t phase_next;
  logic [LEN_W-1:0] token_length;
  logic [LEN_W-1:0] token_length_next;
  logic            decided;
  logic            decided_next;
  logic            failed;
  logic            failed_next;

  nlr_pkg::step_t  step;
  logic            ok;
  logic [31:0]     len_ext;
  nlr_pkg::out_t   result_next;

  nlr_step u_step (
    .phase     (phase),
    .text_byte (s1_data.text_byte),
    .step      (step)
  );

  assign s1_fire    = s1_valid && (!s1_data.span_end || !result_valid || result_ready);
  assign byte_ready = !s1_valid || s1_fire;

  always_comb begin
    phase_next        = phase;
    token_length_next = token_length;
    decided_next      = decided;
    failed_next       = failed;
    if (!decided && !failed) begin
      if (step.take) begin
        phase_next = step.phase;
        if (token_length < LEN_W'(MAX_LEN)) begin
          token_length_next = token_length + LEN_W'(1);
        end
      end
      decided_next = step.decide;
      failed_next  = step.fail;
    end

    // A span that stops before any digit, or inside an exponent, is no literal.
    ok = !failed_next &&
         !(!decided_next && (phase_next == nlr_pkg::PH_START ||
                             phase_next == nlr_pkg::PH_SIGN ||
                             phase_next == nlr_pkg::PH_EXP ||
                             phase_next == nlr_pkg::PH_EXPSIGN));
    len_ext = 32'(token_length_next);
    result_next.matched = ok;
    if (!ok) begin
      result_next.match_length = 8'd0;
    end else if (len_ext > 32'(nlr_pkg::OUT_LEN_MAX)) begin
      result_next.match_length = 8'(nlr_pkg::OUT_LEN_MAX);
    end else begin
      result_next.match_length = len_ext[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      phase        <= nlr_pkg::PH_START;
      token_length <= '0;
      decided      <= 1'b0;
      failed       <= 1'b0;
    end else begin
      if (byte_ready) begin
        s1_valid <= byte_valid;
      end

      if (s1_fire && s1_data.span_end) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      if (s1_fire) begin
        if (s1_data.span_end) begin
          phase        <= nlr_pkg::PH_START;
          token_length <= '0;
          decided      <= 1'b0;
          failed       <= 1'b0;
        end else begin
          phase        <= phase_next;
          token_length <= token_length_next;
          decided      <= decided_next;
          failed       <= failed_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      s1_data <= byte_data;
    end
    if (s1_fire && s1_data.span_end) begin
      result_data <= result_next;
    end
  end

  a_len_matches_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_data.matched == (result_data.match_length != 8'd0)))
    else $error("match_length disagrees with matched");

  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_data.span_end) |=>
      (phase == nlr_pkg::PH_START && token_length == '0 && !decided && !failed))
    else $error("lexer state not cleared after span end");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(decided && failed))
    else $error("literal both ended and failed");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    32'(token_length) <= MAX_LEN)
    else $error("token length above limit");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result_data)))
    else $error("pending result changed before it was taken");

endmodule

// ----- src/nlr_step.sv -----
// Phase transition logic: classifies one byte against the current lexer phase.
// Depends on nlr_pkg.
module nlr_step (
  input  nlr_pkg::phase_t    phase,
  input  logic [7:0]         text_byte,
  output nlr_pkg::step_t     step
);

  logic dec;
  logic sgn;
  logic sfx;
  logic is_e;

  assign dec  = nlr_pkg::is_dec(text_byte);
  assign sgn  = nlr_pkg::is_sign(text_byte);
  assign sfx  = nlr_pkg::is_sfx(text_byte);
  assign is_e = (text_byte == nlr_pkg::CH_LO_E) || (text_byte == nlr_pkg::CH_UP_E);

  always_comb begin
    step.phase  = phase;
    step.take   = 1'b0;
    step.decide = 1'b0;
    step.fail   = 1'b0;
    unique case (phase)
      nlr_pkg::PH_START: begin
        if (dec) begin
          step.take = 1'b1; step.phase = nlr_pkg::PH_INT;
        end else if (sgn) begin
          step.take = 1'b1; step.phase = nlr_pkg::PH_SIGN;
        end else begin
          step.fail = 1'b1;
        end
      end
      nlr_pkg::PH_SIGN: begin
        if (dec) begin
          step.take = 1'b1; step.phase = nlr_pkg::PH_INT;
        end else begin
          step.fail = 1'b1;
        end
      end
      nlr_pkg::PH_INT: begin
        step.take = 1'b1;
        if (dec) begin
          step.phase = nlr_pkg::PH_INT;
        end else if (text_byte == nlr_pkg::CH_DOT) begin
          step.phase = nlr_pkg::PH_FRAC;
        end else if (text_byte == nlr_pkg::CH_LO_X || text_byte == nlr_pkg::CH_UP_X) begin
          step.phase = nlr_pkg::PH_HEX;
        end else if (text_byte == nlr_pkg::CH_LO_B || text_byte == nlr_pkg::CH_UP_B) begin
          step.phase = nlr_pkg::PH_BIN;
        end else if (is_e) begin
          step.phase = nlr_pkg::PH_EXP;
        end else if (text_byte == nlr_pkg::CH_LO_F || sfx) begin
          // An integer may take an f and then still any u/l suffix.
          step.phase = nlr_pkg::PH_SUFFIX;
        end else begin
          step.take = 1'b0; step.decide = 1'b1;
        end
      end
      nlr_pkg::PH_FRAC: begin
        if (dec) begin
          step.take = 1'b1;
        end else if (is_e) begin
          step.take = 1'b1; step.phase = nlr_pkg::PH_EXP;
        end else if (text_byte == nlr_pkg::CH_LO_F) begin
          step.take = 1'b1; step.decide = 1'b1;
        end else begin
          step.decide = 1'b1;
        end
      end
      nlr_pkg::PH_HEX: begin
        if (nlr_pkg::is_hexd(text_byte)) begin
          step.take = 1'b1;
        end else if (sfx) begin
          step.take = 1'b1; step.phase = nlr_pkg::PH_SUFFIX;
        end else begin
          step.decide = 1'b1;
        end
      end
      nlr_pkg::PH_BIN: begin
        if (text_byte == nlr_pkg::CH_0 || text_byte == nlr_pkg::CH_1) begin
          step.take = 1'b1;
        end else if (sfx) begin
          step.take = 1'b1; step.phase = nlr_pkg::PH_SUFFIX;
        end else begin
          step.decide = 1'b1;
        end
      end
      nlr_pkg::PH_EXP: begin
        if (sgn) begin
          step.take = 1'b1; step.phase = nlr_pkg::PH_EXPSIGN;
        end else if (dec) begin
          step.take = 1'b1; step.phase = nlr_pkg::PH_EXPDIG;
        end else begin
          step.fail = 1'b1;
        end
      end
      nlr_pkg::PH_EXPSIGN: begin
        if (dec) begin
          step.take = 1'b1; step.phase = nlr_pkg::PH_EXPDIG;
        end else begin
          step.fail = 1'b1;
        end
      end
      nlr_pkg::PH_EXPDIG: begin
        if (dec) begin
          step.take = 1'b1;
        end else if (text_byte == nlr_pkg::CH_LO_F) begin
          step.take = 1'b1; step.decide = 1'b1;
        end else begin
          step.decide = 1'b1;
        end
      end
      nlr_pkg::PH_SUFFIX: begin
        if (sfx) begin
          step.take = 1'b1;
        end else begin
          step.decide = 1'b1;
        end
      end
      default: begin
        step.fail = 1'b1;
      end
    endcase
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for number_literal_recognizer: sends text spans as byte
// requests, predicts each match result and compares it. Depends on nlr_pkg and the RTL.
module tb_top;

  localparam int unsigned MAX_LEN = 255;
  localparam int unsigned RANDOM_BYTES = 1250;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef logic [7:0] text_q_t[$];
  typedef enum {PART_NONE, PART_FRAC, PART_HEX, PART_BIN} part_t;
  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_BLOCKED} rx_mode_t;

  class literal_scoreboard;
    nlr_pkg::phase_t phase;
    logic [7:0]      token_len;
    logic            decided;
    logic            failed;
    nlr_pkg::out_t   expected_matches[$];
    int              mismatches;

    function new();
      mismatches = 0;
      clear_span();
    endfunction

    function void clear_span();
      phase = nlr_pkg::PH_START;
      token_len = '0;
      decided = 1'b0;
      failed = 1'b0;
    endfunction

    function bit digit_char(logic [7:0] c);
      return c >= nlr_pkg::CH_0 && c <= nlr_pkg::CH_9;
    endfunction

    function bit hex_char(logic [7:0] c);
      return digit_char(c) || (c >= nlr_pkg::CH_LO_A && c <= nlr_pkg::CH_LO_F) ||
             (c >= nlr_pkg::CH_UP_A && c <= nlr_pkg::CH_UP_F);
    endfunction

    function bit suffix_char(logic [7:0] c);
      return c == nlr_pkg::CH_LO_U || c == nlr_pkg::CH_UP_U ||
             c == nlr_pkg::CH_LO_L || c == nlr_pkg::CH_UP_L;
    endfunction

    function bit sign_char(logic [7:0] c);
      return c == nlr_pkg::CH_PLUS || c == nlr_pkg::CH_MINUS;
    endfunction

    function void accept(nlr_pkg::phase_t nxt);
      if (token_len < MAX_LEN) token_len++;
      phase = nxt;
    endfunction

    function void lex_byte(logic [7:0] c);
      case (phase)
        nlr_pkg::PH_START: begin
          if (digit_char(c)) accept(nlr_pkg::PH_INT);
          else if (sign_char(c)) accept(nlr_pkg::PH_SIGN);
          else failed = 1'b1;
        end
        nlr_pkg::PH_SIGN: begin
          if (digit_char(c)) accept(nlr_pkg::PH_INT);
          else failed = 1'b1;
        end
        nlr_pkg::PH_INT: begin
          if (digit_char(c)) accept(nlr_pkg::PH_INT);
          else if (c == nlr_pkg::CH_DOT) accept(nlr_pkg::PH_FRAC);
          else if (c == nlr_pkg::CH_LO_X || c == nlr_pkg::CH_UP_X) accept(nlr_pkg::PH_HEX);
          else if (c == nlr_pkg::CH_LO_B || c == nlr_pkg::CH_UP_B) accept(nlr_pkg::PH_BIN);
          else if (c == nlr_pkg::CH_LO_E || c == nlr_pkg::CH_UP_E) accept(nlr_pkg::PH_EXP);
          else if (c == nlr_pkg::CH_LO_F || suffix_char(c)) accept(nlr_pkg::PH_SUFFIX);
          else decided = 1'b1;
        end
        nlr_pkg::PH_FRAC: begin
          if (digit_char(c)) accept(nlr_pkg::PH_FRAC);
          else if (c == nlr_pkg::CH_LO_E || c == nlr_pkg::CH_UP_E) accept(nlr_pkg::PH_EXP);
          else if (c == nlr_pkg::CH_LO_F) begin
            accept(nlr_pkg::PH_FRAC);
            decided = 1'b1;
          end else decided = 1'b1;
        end
        nlr_pkg::PH_HEX: begin
          if (hex_char(c)) accept(nlr_pkg::PH_HEX);
          else if (suffix_char(c)) accept(nlr_pkg::PH_SUFFIX);
          else decided = 1'b1;
        end
        nlr_pkg::PH_BIN: begin
          if (c == nlr_pkg::CH_0 || c == nlr_pkg::CH_1) accept(nlr_pkg::PH_BIN);
          else if (suffix_char(c)) accept(nlr_pkg::PH_SUFFIX);
          else decided = 1'b1;
        end
        nlr_pkg::PH_EXP: begin
          if (sign_char(c)) accept(nlr_pkg::PH_EXPSIGN);
          else if (digit_char(c)) accept(nlr_pkg::PH_EXPDIG);
          else failed = 1'b1;
        end
        nlr_pkg::PH_EXPSIGN: begin
          if (digit_char(c)) accept(nlr_pkg::PH_EXPDIG);
          else failed = 1'b1;
        end
        nlr_pkg::PH_EXPDIG: begin
          if (digit_char(c)) accept(nlr_pkg::PH_EXPDIG);
          else if (c == nlr_pkg::CH_LO_F) begin
            accept(nlr_pkg::PH_EXPDIG);
            decided = 1'b1;
          end else decided = 1'b1;
        end
        nlr_pkg::PH_SUFFIX: begin
          if (suffix_char(c)) accept(nlr_pkg::PH_SUFFIX);
          else decided = 1'b1;
        end
        default: failed = 1'b1;
      endcase
    endfunction

    function void note_byte(nlr_pkg::in_t req);
      nlr_pkg::out_t m;
      logic ok;
      if (!decided && !failed) lex_byte(req.text_byte);
      if (req.span_end) begin
        ok = !failed;
        // A span that stops after a sign or inside an exponent is no literal.
        if (ok && !decided && phase inside {nlr_pkg::PH_START, nlr_pkg::PH_SIGN,
                                            nlr_pkg::PH_EXP, nlr_pkg::PH_EXPSIGN})
          ok = 1'b0;
        m.matched = ok;
        m.match_length = ok ? token_len : 8'd0;
        expected_matches.push_back(m);
        clear_span();
      end
    endfunction

    function void check_match(nlr_pkg::out_t got);
      nlr_pkg::out_t want;
      if (expected_matches.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result matched=%0d length=%0d",
                   got.matched, got.match_length);
        return;
      end
      want = expected_matches.pop_front();
      if (got.matched !== want.matched || got.match_length !== want.match_length) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: matched exp %0d got %0d, length exp %0d got %0d",
                   want.matched, got.matched, want.match_length, got.match_length);
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          byte_valid = 1'b0;
  logic          byte_ready;
  nlr_pkg::in_t  byte_data = '0;
  logic          result_valid;
  logic          result_ready = 1'b0;
  nlr_pkg::out_t result_data;

  int unsigned  cycles = 0;
  int           burst_left = 0;
  rx_mode_t     rx_mode = RX_OPEN;
  literal_scoreboard sb;

  number_literal_recognizer #(.MAX_LEN(MAX_LEN)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // The receiver switches between open, random, sparse and blocked stretches.
  always @(posedge clk) begin
    if (cycles % 97 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   result_ready <= 1'b1;
      RX_RANDOM: result_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: result_ready <= (cycles % 5 == 0);
      default:   result_ready <= (cycles % 16 >= 12);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_match(result_data);
  end

  function automatic logic [7:0] pick(string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  function automatic text_q_t span_of(string s);
    text_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // Mostly well-formed literals with random content, some noise and corruption.
  function automatic text_q_t make_span();
    text_q_t s;
    part_t part;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 6)) s.push_back(8'($urandom_range(0, 255)));
      return s;
    end
    if ($urandom_range(0, 3) == 0) s.push_back(pick("+-"));
    repeat ($urandom_range(1, 4)) s.push_back(pick("0123456789"));
    part = part_t'($urandom_range(0, 3));
    case (part)
      PART_FRAC: begin
        s.push_back(nlr_pkg::CH_DOT);
        repeat ($urandom_range(0, 3)) s.push_back(pick("0123456789"));
      end
      PART_HEX: begin
        s.push_back(pick("xX"));
        repeat ($urandom_range(0, 4)) s.push_back(pick("0123456789abcdefABCDEF"));
      end
      PART_BIN: begin
        s.push_back(pick("bB"));
        repeat ($urandom_range(0, 4)) s.push_back(pick("01"));
      end
      default: ;
    endcase
    if (part inside {PART_NONE, PART_FRAC} && $urandom_range(0, 2) == 0) begin
      s.push_back(pick("eE"));
      if ($urandom_range(0, 1)) s.push_back(pick("+-"));
      repeat ($urandom_range(0, 3)) s.push_back(pick("0123456789"));
    end
    if (part inside {PART_NONE, PART_FRAC} && $urandom_range(0, 2) == 0)
      s.push_back(nlr_pkg::CH_LO_F);
    if ($urandom_range(0, 1)) repeat ($urandom_range(1, 3)) s.push_back(pick("uUlL"));
    repeat ($urandom_range(0, 3)) s.push_back(pick("0123456789+-.xXbBeEfFuUlLaz "));
    if ($urandom_range(0, 7) == 0) s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
    return s;
  endfunction

  // Sends one byte request in bursts; returns at the edge where it is accepted.
  task automatic send_byte(input logic [7:0] b, input logic last);
    nlr_pkg::in_t req;
    req.text_byte = b;
    req.span_end = last;
    if (burst_left == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(1, 12);
    end
    burst_left--;
    byte_valid <= 1'b1;
    byte_data <= req;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    sb.note_byte(req);
  endtask

  task automatic send_span(input text_q_t s);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  task automatic wait_drained();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_matches.size() != 0) @(posedge clk);
  endtask

  initial begin
    text_q_t span;
    int sent;
    int spans;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_span(span_of("0x"));
    send_span(span_of("12fu"));
    send_span(span_of("1.5fu"));
    send_span(span_of("1e"));
    send_span(span_of("1e-"));
    send_span(span_of("-"));
    send_span(span_of("+a"));
    send_span(span_of("7;x"));
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    wait_drained();

    sent = 0;
    spans = 0;
    while (sent < RANDOM_BYTES) begin
      if (spans == 10 || spans == 70) begin
        // Literal longer than the length limit.
        span = {};
        repeat ($urandom_range(256, 290)) span.push_back(pick("0123456789"));
      end else begin
        span = make_span();
      end
      sent += span.size();
      send_span(span);
      spans++;
      if (spans % 60 == 0) wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_matches.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
